// ===== hw/rtl/efr_pkg.sv =====
// Shared types and constants for the escaped frame receiver.
// Used by the front end, the word queue, the back end and the top level.
// Depends on nothing else.
package efr_pkg;

    // Configuration register indexes.
    localparam logic [2:0] CFG_EXPECTED_TYPE = 3'd0;
    localparam logic [2:0] CFG_START_CODE    = 3'd1;
    localparam logic [2:0] CFG_ESCAPE_CODE   = 3'd2;
    localparam logic [2:0] CFG_DATA_CODE     = 3'd3;
    localparam logic [2:0] CFG_ACK_CODE      = 3'd4;
    localparam logic [2:0] CFG_BREAK_CODE    = 3'd5;

    // Reset values of the configuration registers.
    localparam logic [7:0] RST_EXPECTED_TYPE = 8'h01;
    localparam logic [7:0] RST_START_CODE    = 8'h7e;
    localparam logic [7:0] RST_ESCAPE_CODE   = 8'h7d;
    localparam logic [7:0] RST_DATA_CODE     = 8'h01;
    localparam logic [7:0] RST_ACK_CODE      = 8'h02;
    localparam logic [7:0] RST_BREAK_CODE    = 8'h03;

    localparam logic [7:0] XOR_MASK = 8'h20;
    localparam logic [7:0] SUM_GOOD = 8'hff;

    // Input command codes.
    localparam logic CMD_BYTE    = 1'b0;
    localparam logic CMD_TIMEOUT = 1'b1;

    // Result kinds.
    localparam logic KIND_PAYLOAD = 1'b0;
    localparam logic KIND_STATUS  = 1'b1;

    // End of frame status codes.
    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_CSUM    = 2'd1;
    localparam logic [1:0] ST_TIMEOUT = 2'd2;
    localparam logic [1:0] ST_BREAK   = 2'd3;

    typedef struct packed {
        logic [7:0] expected_type;
        logic [7:0] start_code;
        logic [7:0] escape_code;
        logic [7:0] data_code;
        logic [7:0] ack_code;
        logic [7:0] break_code;
    } t_cfg;

    // Operations handed from the front end to the back end.
    typedef enum logic [2:0] {
        OP_TIMEOUT = 3'd0,
        OP_LEN     = 3'd1,
        OP_TYPE    = 3'd2,
        OP_DATA    = 3'd3,
        OP_CHECK   = 3'd4
    } t_op_code;

    typedef struct packed {
        t_op_code   code;
        logic [7:0] value;
        logic [7:0] index;
    } t_op;

    typedef struct packed {
        logic       kind;
        logic [7:0] data_byte;
        logic [7:0] byte_index;
        logic [1:0] status;
        logic [7:0] frame_length;
        logic [7:0] ack_value;
        logic       break_flag;
    } t_result;

endpackage

// ===== hw/rtl/efr_in_if.sv =====
// Input channel of the escaped frame receiver: one received byte or timeout per word.
// Depends on nothing else.
interface efr_in_if;
    logic       valid;
    logic       ready;
    logic       cmd;
    logic [7:0] rx_byte;

    modport source (output valid, output cmd, output rx_byte, input ready);
    modport sink   (input valid, input cmd, input rx_byte, output ready);
endinterface

// ===== hw/rtl/efr_out_if.sv =====
// Output channel of the escaped frame receiver: one payload byte or frame status per word.
// Depends on nothing else.
interface efr_out_if;
    logic       valid;
    logic       ready;
    logic       kind;
    logic [7:0] data_byte;
    logic [7:0] byte_index;
    logic [1:0] status;
    logic [7:0] frame_length;
    logic [7:0] ack_value;
    logic       break_flag;

    modport source (output valid, output kind, output data_byte, output byte_index,
                    output status, output frame_length, output ack_value,
                    output break_flag, input ready);
    modport sink   (input valid, input kind, input data_byte, input byte_index,
                    input status, input frame_length, input ack_value,
                    input break_flag, output ready);
endinterface

// ===== hw/rtl/efr_front.sv =====
// Front end: hunts for the start byte, undoes escapes and tracks the frame layout.
// Each accepted word becomes at most one operation for the back end.
// Depends on efr_pkg and efr_in_if.
module efr_front (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  efr_pkg::t_cfg i_cfg,
    efr_in_if.sink        i_in,
    input  logic          i_q_full,
    output logic          o_push,
    output efr_pkg::t_op  o_op
);

    typedef enum logic [4:0] {
        PH_HUNT  = 5'b00001,
        PH_LEN   = 5'b00010,
        PH_TYPE  = 5'b00100,
        PH_DATA  = 5'b01000,
        PH_CHECK = 5'b10000
    } t_phase;

    t_phase     r_phase, n_phase;
    logic       r_esc, n_esc;
    logic [7:0] r_len, n_len;
    logic [7:0] r_pos, n_pos;
    logic       accept;
    logic [7:0] val;
    logic [7:0] pos_inc;

    assign i_in.ready = !i_q_full;
    assign accept     = i_in.valid && !i_q_full;
    assign val        = r_esc ? (i_in.rx_byte ^ efr_pkg::XOR_MASK) : i_in.rx_byte;
    assign pos_inc    = r_pos + 8'd1;

    always_comb begin
        n_phase = r_phase;
        n_esc   = r_esc;
        n_len   = r_len;
        n_pos   = r_pos;
        o_push  = 1'b0;
        o_op    = '{code: efr_pkg::OP_TIMEOUT, value: val, index: r_pos};
        if (accept) begin
            if (i_in.cmd == efr_pkg::CMD_TIMEOUT) begin
                n_phase = PH_HUNT;
                n_esc   = 1'b0;
                o_push  = 1'b1;
            end else if (r_phase == PH_HUNT) begin
                // Bytes are compared raw while hunting.
                if (i_in.rx_byte == i_cfg.start_code) begin
                    n_phase = PH_LEN;
                    n_esc   = 1'b0;
                    n_pos   = 8'd0;
                end
            end else if (!r_esc && i_in.rx_byte == i_cfg.escape_code) begin
                n_esc = 1'b1;
            end else begin
                n_esc  = 1'b0;
                o_push = 1'b1;
                case (r_phase)
                    PH_LEN: begin
                        o_op.code = efr_pkg::OP_LEN;
                        n_len     = val;
                        n_phase   = PH_TYPE;
                    end
                    PH_TYPE: begin
                        o_op.code = efr_pkg::OP_TYPE;
                        n_pos     = 8'd0;
                        n_phase   = (r_len == 8'd0) ? PH_CHECK : PH_DATA;
                    end
                    PH_DATA: begin
                        o_op.code = efr_pkg::OP_DATA;
                        n_pos     = pos_inc;
                        if (pos_inc == r_len) begin
                            n_phase = PH_CHECK;
                        end
                    end
                    PH_CHECK: begin
                        o_op.code = efr_pkg::OP_CHECK;
                        n_phase   = PH_HUNT;
                    end
                    default: begin
                        o_push  = 1'b0;
                        n_phase = PH_HUNT;
                    end
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_HUNT;
            r_esc   <= 1'b0;
            r_len   <= 8'd0;
            r_pos   <= 8'd0;
        end else begin
            r_phase <= n_phase;
            r_esc   <= n_esc;
            r_len   <= n_len;
            r_pos   <= n_pos;
        end
    end

endmodule

// ===== hw/rtl/efr_queue.sv =====
// Two-entry operation queue between the front end and the back end.
// Depends on efr_pkg.
module efr_queue (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_push,
    input  efr_pkg::t_op i_op,
    input  logic         i_pop,
    output logic         o_full,
    output logic         o_valid,
    output efr_pkg::t_op o_op
);

    efr_pkg::t_op r_mem [2];
    logic [0:0]   r_wr_ptr;
    logic [0:0]   r_rd_ptr;
    logic [1:0]   r_count, n_count;
    logic         do_pop;

    assign o_full  = (r_count == 2'd2);
    assign o_valid = (r_count != 2'd0);
    assign o_op    = r_mem[r_rd_ptr];
    assign do_pop  = i_pop && o_valid;
    assign n_count = r_count + {1'b0, i_push} - {1'b0, do_pop};

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_op;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= 2'd0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (do_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            r_count <= n_count;
        end
    end

endmodule

// ===== hw/rtl/efr_back.sv =====
// Back end: keeps the frame sums, the ack value and the break state, and forms results.
// Results wait in an output register so the queue keeps draining while it is free.
// Depends on efr_pkg and efr_out_if.
module efr_back (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  efr_pkg::t_cfg i_cfg,
    input  logic          i_q_valid,
    input  efr_pkg::t_op  i_op,
    output logic          o_pop,
    efr_out_if.source     o_out
);

    logic [7:0]       r_len, n_len;
    logic [7:0]       r_type, n_type;
    logic [7:0]       r_sum, n_sum;
    logic [7:0]       r_ack, n_ack;
    logic             r_brk, n_brk;
    logic             r_out_valid;
    efr_pkg::t_result r_out;
    logic             res_valid;
    logic             res_kind;
    logic [7:0]       res_data;
    logic [7:0]       res_index;
    logic [1:0]       res_status;
    logic [7:0]       sum_add;
    logic             type_ok;

    assign o_pop   = i_q_valid && (!r_out_valid || o_out.ready);
    assign sum_add = r_sum + i_op.value;
    assign type_ok = (r_type == i_cfg.expected_type);

    always_comb begin
        n_len      = r_len;
        n_type     = r_type;
        n_sum      = r_sum;
        n_ack      = r_ack;
        n_brk      = r_brk;
        res_valid  = 1'b0;
        res_kind   = efr_pkg::KIND_STATUS;
        res_data   = 8'd0;
        res_index  = 8'd0;
        res_status = efr_pkg::ST_OK;
        if (o_pop) begin
            case (i_op.code)
                efr_pkg::OP_TIMEOUT: begin
                    res_valid  = 1'b1;
                    res_status = efr_pkg::ST_TIMEOUT;
                end
                efr_pkg::OP_LEN: begin
                    n_len = i_op.value;
                end
                efr_pkg::OP_TYPE: begin
                    n_type = i_op.value;
                    n_sum  = i_op.value;
                end
                efr_pkg::OP_DATA: begin
                    n_sum = sum_add;
                    if (r_type != i_cfg.data_code) begin
                        n_ack = i_op.value;
                    end
                    if (type_ok && r_type == i_cfg.data_code) begin
                        res_valid = 1'b1;
                        res_kind  = efr_pkg::KIND_PAYLOAD;
                        res_data  = i_op.value;
                        res_index = i_op.index;
                    end
                end
                efr_pkg::OP_CHECK: begin
                    n_sum = sum_add;
                    if (type_ok) begin
                        res_valid = 1'b1;
                        // A break request skips the checksum test.
                        if (r_type == i_cfg.ack_code && r_ack == i_cfg.break_code) begin
                            n_brk      = 1'b1;
                            res_status = efr_pkg::ST_BREAK;
                        end else begin
                            if (r_type == i_cfg.data_code) begin
                                n_brk = 1'b0;
                            end
                            res_status = (sum_add == efr_pkg::SUM_GOOD) ?
                                         efr_pkg::ST_OK : efr_pkg::ST_CSUM;
                        end
                    end
                end
                default: begin
                    res_valid = 1'b0;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_len       <= 8'd0;
            r_type      <= 8'd0;
            r_sum       <= 8'd0;
            r_ack       <= 8'd0;
            r_brk       <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_len  <= n_len;
            r_type <= n_type;
            r_sum  <= n_sum;
            r_ack  <= n_ack;
            r_brk  <= n_brk;
            if (res_valid) begin
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (res_valid) begin
            r_out <= '{kind: res_kind, data_byte: res_data, byte_index: res_index,
                       status: res_status, frame_length: n_len, ack_value: n_ack,
                       break_flag: n_brk};
        end
    end

    assign o_out.valid        = r_out_valid;
    assign o_out.kind         = r_out.kind;
    assign o_out.data_byte    = r_out.data_byte;
    assign o_out.byte_index   = r_out.byte_index;
    assign o_out.status       = r_out.status;
    assign o_out.frame_length = r_out.frame_length;
    assign o_out.ack_value    = r_out.ack_value;
    assign o_out.break_flag   = r_out.break_flag;

    // A timeout taken from the queue must show up as a timeout status word.
    a_timeout_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_pop && i_op.code == efr_pkg::OP_TIMEOUT) |=>
        (r_out_valid && r_out.kind == efr_pkg::KIND_STATUS
         && r_out.status == efr_pkg::ST_TIMEOUT))
        else $error("timeout did not give a timeout status");

    // A break status always reports the break as set.
    a_break_flag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out.kind == efr_pkg::KIND_STATUS
         && r_out.status == efr_pkg::ST_BREAK) |-> r_out.break_flag)
        else $error("break status without break flag");

    // A held result that is not taken must not be overwritten by a new pop.
    a_no_overrun: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !o_out.ready) |-> !o_pop)
        else $error("queue popped while result stalled");

endmodule

// ===== hw/rtl/escaped_frame_receiver_unit.sv =====
// Escaped frame receiver: deframes byte-stuffed frames from a serial byte stream.
// Throughput: one input word per clock cycle whatever the frame content; only a stalled
// output holds the input off, once the output register and the two-entry queue are full.
// Path of a result: the front end writes the operation for its word into the two-entry queue,
// then the back end takes it from there and writes the result into the output register.
// Reset is synchronous and active low: configuration returns to its defaults and
// all frame, ack and break state clears; the queue and output register empty.
module escaped_frame_receiver_unit (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_cfg_we,
    input  logic [2:0] i_cfg_idx,
    input  logic [7:0] i_cfg_data,
    efr_in_if.sink     i_in,
    efr_out_if.source  o_out
);

    efr_pkg::t_cfg r_cfg;
    logic          q_full;
    logic          q_valid;
    logic          push;
    logic          pop;
    efr_pkg::t_op  push_op;
    efr_pkg::t_op  head_op;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.expected_type <= efr_pkg::RST_EXPECTED_TYPE;
            r_cfg.start_code    <= efr_pkg::RST_START_CODE;
            r_cfg.escape_code   <= efr_pkg::RST_ESCAPE_CODE;
            r_cfg.data_code     <= efr_pkg::RST_DATA_CODE;
            r_cfg.ack_code      <= efr_pkg::RST_ACK_CODE;
            r_cfg.break_code    <= efr_pkg::RST_BREAK_CODE;
        end else if (i_cfg_we) begin
            // Indexes beyond the last register fall through and are ignored.
            case (i_cfg_idx)
                efr_pkg::CFG_EXPECTED_TYPE: r_cfg.expected_type <= i_cfg_data;
                efr_pkg::CFG_START_CODE:    r_cfg.start_code    <= i_cfg_data;
                efr_pkg::CFG_ESCAPE_CODE:   r_cfg.escape_code   <= i_cfg_data;
                efr_pkg::CFG_DATA_CODE:     r_cfg.data_code     <= i_cfg_data;
                efr_pkg::CFG_ACK_CODE:      r_cfg.ack_code      <= i_cfg_data;
                efr_pkg::CFG_BREAK_CODE:    r_cfg.break_code    <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    efr_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cfg    (r_cfg),
        .i_in     (i_in),
        .i_q_full (q_full),
        .o_push   (push),
        .o_op     (push_op)
    );

    efr_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_op    (push_op),
        .i_pop   (pop),
        .o_full  (q_full),
        .o_valid (q_valid),
        .o_op    (head_op)
    );

    efr_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cfg     (r_cfg),
        .i_q_valid (q_valid),
        .i_op      (head_op),
        .o_pop     (pop),
        .o_out     (o_out)
    );

endmodule

// ===== tb/sv/tb_escaped_frame_receiver_unit.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for escaped_frame_receiver_unit: directed and random framed byte streams.
// Depends on efr_pkg, efr_in_if, efr_out_if and the receiver RTL; it reads no files.
module tb_escaped_frame_receiver_unit;

    localparam int IDLE_PCT         = 22;
    localparam int HOLD_AFTER_WORDS = 200;
    localparam int HOLD_CYCLES      = 120;
    localparam int BURST_FROM       = 420;
    localparam int BURST_TO         = 560;
    localparam int DRAIN_CYCLES     = 4;
    localparam int CYCLE_LIMIT      = 200000;
    localparam int MAX_REPORTS      = 50;

    // Indexes that decode to no register; writes to them must be ignored.
    localparam logic [2:0] CFG_SPARE_LO = 3'd6;
    localparam logic [2:0] CFG_SPARE_HI = 3'd7;

    typedef struct packed {
        logic       cmd;
        logic [7:0] rx_byte;
    } t_rx_word;

    typedef enum logic [2:0] {
        RX_HUNT,
        RX_LEN,
        RX_TYPE,
        RX_DATA,
        RX_CHECK
    } t_rx_phase;

    logic       i_clk = 1'b0;
    logic       i_rst_n;
    logic       i_cfg_we;
    logic [2:0] i_cfg_idx;
    logic [7:0] i_cfg_data;

    efr_in_if  in_ch ();
    efr_out_if out_ch ();

    escaped_frame_receiver_unit dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_in       (in_ch),
        .o_out      (out_ch)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    t_rx_word          rx_stream[$];
    efr_pkg::t_result  pending_results[$];

    // Deframer state and register copy used for prediction.
    efr_pkg::t_cfg cfg_now;
    t_rx_phase rx_phase;
    logic      esc_armed;
    logic [7:0] len_seen;
    logic [7:0] type_seen;
    logic [7:0] pay_pos;
    logic [7:0] csum_acc;
    logic [7:0] ack_held;
    logic      break_on;

    int words_sent     = 0;
    int words_queued   = 0;
    int results_seen   = 0;
    int payload_count  = 0;
    int status_count   = 0;
    int break_count    = 0;
    int settings_count = 0;
    int fail_count     = 0;
    int cycle_count    = 0;
    int hold_left      = 0;
    bit hold_fired     = 1'b0;

    task automatic note_mismatch(input string what);
        fail_count++;
        if (fail_count <= MAX_REPORTS) begin
            $display("MISMATCH at cycle %0d: %s", cycle_count, what);
        end
    endtask

    function automatic void expect_result(input logic kind, input logic [7:0] data,
                                          input logic [7:0] idx, input logic [1:0] status);
        efr_pkg::t_result r;
        r.kind         = kind;
        r.data_byte    = data;
        r.byte_index   = idx;
        r.status       = status;
        r.frame_length = len_seen;
        r.ack_value    = ack_held;
        r.break_flag   = break_on;
        pending_results.push_back(r);
    endfunction

    // Advances the deframer by one accepted word and queues the result it causes, if any.
    function automatic void deframe_word(input logic cmd, input logic [7:0] b);
        logic [7:0] v;
        logic [7:0] idx;
        if (cmd == efr_pkg::CMD_TIMEOUT) begin
            rx_phase  = RX_HUNT;
            esc_armed = 1'b0;
            expect_result(efr_pkg::KIND_STATUS, 8'h00, 8'h00, efr_pkg::ST_TIMEOUT);
            return;
        end
        if (rx_phase == RX_HUNT) begin
            if (b == cfg_now.start_code) begin
                rx_phase  = RX_LEN;
                esc_armed = 1'b0;
                pay_pos   = 8'h00;
            end
            return;
        end
        if (!esc_armed && b == cfg_now.escape_code) begin
            esc_armed = 1'b1;
            return;
        end
        v = esc_armed ? (b ^ efr_pkg::XOR_MASK) : b;
        esc_armed = 1'b0;
        case (rx_phase)
            RX_LEN: begin
                len_seen = v;
                rx_phase = RX_TYPE;
            end
            RX_TYPE: begin
                type_seen = v;
                csum_acc  = v;
                pay_pos   = 8'h00;
                rx_phase  = (len_seen == 8'h00) ? RX_CHECK : RX_DATA;
            end
            RX_DATA: begin
                idx      = pay_pos;
                csum_acc = csum_acc + v;
                if (type_seen != cfg_now.data_code) begin
                    ack_held = v;
                end
                pay_pos = pay_pos + 8'h01;
                if (pay_pos == len_seen) begin
                    rx_phase = RX_CHECK;
                end
                if (type_seen == cfg_now.expected_type && type_seen == cfg_now.data_code) begin
                    expect_result(efr_pkg::KIND_PAYLOAD, v, idx, efr_pkg::ST_OK);
                end
            end
            RX_CHECK: begin
                csum_acc = csum_acc + v;
                rx_phase = RX_HUNT;
                if (type_seen == cfg_now.expected_type) begin
                    if (type_seen == cfg_now.ack_code && ack_held == cfg_now.break_code) begin
                        break_on = 1'b1;
                        expect_result(efr_pkg::KIND_STATUS, 8'h00, 8'h00, efr_pkg::ST_BREAK);
                    end else begin
                        if (type_seen == cfg_now.data_code) begin
                            break_on = 1'b0;
                        end
                        expect_result(efr_pkg::KIND_STATUS, 8'h00, 8'h00,
                                      (csum_acc == efr_pkg::SUM_GOOD) ?
                                      efr_pkg::ST_OK : efr_pkg::ST_CSUM);
                    end
                end
            end
            default: rx_phase = RX_HUNT;
        endcase
    endfunction

    task automatic check_result();
        efr_pkg::t_result got;
        efr_pkg::t_result want;
        got = '{kind: out_ch.kind, data_byte: out_ch.data_byte, byte_index: out_ch.byte_index,
                status: out_ch.status, frame_length: out_ch.frame_length,
                ack_value: out_ch.ack_value, break_flag: out_ch.break_flag};
        results_seen++;
        if (got.kind == efr_pkg::KIND_PAYLOAD) begin
            payload_count++;
        end else begin
            status_count++;
            if (got.status == efr_pkg::ST_BREAK) begin
                break_count++;
            end
        end
        if (pending_results.size() == 0) begin
            note_mismatch($sformatf("unexpected word kind %0d status %0d data %02h",
                                    got.kind, got.status, got.data_byte));
            return;
        end
        want = pending_results.pop_front();
        if (got.kind !== want.kind)
            note_mismatch($sformatf("kind %0d, expected %0d", got.kind, want.kind));
        if (got.data_byte !== want.data_byte)
            note_mismatch($sformatf("data_byte %02h, expected %02h",
                                    got.data_byte, want.data_byte));
        if (got.byte_index !== want.byte_index)
            note_mismatch($sformatf("byte_index %0d, expected %0d",
                                    got.byte_index, want.byte_index));
        if (got.status !== want.status)
            note_mismatch($sformatf("status %0d, expected %0d", got.status, want.status));
        if (got.frame_length !== want.frame_length)
            note_mismatch($sformatf("frame_length %0d, expected %0d",
                                    got.frame_length, want.frame_length));
        if (got.ack_value !== want.ack_value)
            note_mismatch($sformatf("ack_value %02h, expected %02h",
                                    got.ack_value, want.ack_value));
        if (got.break_flag !== want.break_flag)
            note_mismatch($sformatf("break_flag %0d, expected %0d",
                                    got.break_flag, want.break_flag));
    endtask

    function automatic bit no_gaps();
        return (words_sent >= BURST_FROM) && (words_sent < BURST_TO);
    endfunction

    // Driver: offers queued words and feeds every accepted one to the deframer model.
    always @(posedge i_clk) begin : feed
        t_rx_word w;
        if (!i_rst_n) begin
            in_ch.valid <= 1'b0;
        end else begin
            if (in_ch.valid && in_ch.ready) begin
                deframe_word(in_ch.cmd, in_ch.rx_byte);
                words_sent <= words_sent + 1;
            end
            if (!in_ch.valid || in_ch.ready) begin
                if (rx_stream.size() != 0 && (no_gaps() || $urandom_range(99) >= IDLE_PCT)) begin
                    w = rx_stream.pop_front();
                    in_ch.valid   <= 1'b1;
                    in_ch.cmd     <= w.cmd;
                    in_ch.rx_byte <= w.rx_byte;
                end else begin
                    in_ch.valid <= 1'b0;
                end
            end
        end
    end

    // One long hold-off of the receiver while results are waiting, so that the block backs up.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            hold_left <= 0;
        end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
        end else if (!hold_fired && words_sent >= HOLD_AFTER_WORDS
                     && pending_results.size() != 0) begin
            hold_left  <= HOLD_CYCLES;
            hold_fired <= 1'b1;
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            out_ch.ready <= 1'b0;
        end else begin
            if (out_ch.valid && out_ch.ready) begin
                check_result();
            end
            out_ch.ready <= (hold_left == 0) && (no_gaps() || $urandom_range(99) >= IDLE_PCT);
        end
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Run timed out with %0d results still awaited", pending_results.size());
            $display("*** FAILED ***");
            $finish;
        end
    end

    task automatic push_word(input logic cmd, input logic [7:0] b);
        rx_stream.push_back('{cmd: cmd, rx_byte: b});
        words_queued++;
    endtask

    // Bytes offered while hunting that are never the start code are simply dropped.
    task automatic push_noise(input int count);
        logic [7:0] b;
        for (int k = 0; k < count; k++) begin
            b = 8'($urandom);
            if (b == cfg_now.start_code) begin
                b = ~b;
            end
            rx_stream.push_back('{cmd: efr_pkg::CMD_BYTE, rx_byte: b});
        end
    endtask

    // Encodes one frame with random escaping; a truncated frame is closed by a timeout.
    task automatic queue_frame(input logic [7:0] ftype, input int len, input bit to_break,
                               input bit good_sum, input bit truncate);
        logic [7:0] body[$];
        t_rx_word   enc[$];
        logic [7:0] sum;
        logic [7:0] v;
        int         cut;
        sum = ftype;
        body.push_back(8'(len));
        body.push_back(ftype);
        for (int k = 0; k < len; k++) begin
            v = (to_break && k == len - 1) ? cfg_now.break_code : 8'($urandom);
            sum = sum + v;
            body.push_back(v);
        end
        v = efr_pkg::SUM_GOOD - sum;
        if (!good_sum) begin
            v = v ^ 8'($urandom_range(255, 1));
        end
        body.push_back(v);
        enc.push_back('{cmd: efr_pkg::CMD_BYTE, rx_byte: cfg_now.start_code});
        foreach (body[k]) begin
            if (body[k] == cfg_now.escape_code || $urandom_range(99) < 10) begin
                enc.push_back('{cmd: efr_pkg::CMD_BYTE, rx_byte: cfg_now.escape_code});
                enc.push_back('{cmd: efr_pkg::CMD_BYTE,
                                rx_byte: body[k] ^ efr_pkg::XOR_MASK});
            end else begin
                enc.push_back('{cmd: efr_pkg::CMD_BYTE, rx_byte: body[k]});
            end
        end
        cut = truncate ? $urandom_range(enc.size() - 1, 1) : enc.size();
        for (int k = 0; k < cut; k++) begin
            push_word(enc[k].cmd, enc[k].rx_byte);
        end
        if (truncate) begin
            push_word(efr_pkg::CMD_TIMEOUT, 8'($urandom));
        end
    endtask

    task automatic random_traffic(input int target);
        int         stop_at;
        int         pick;
        int         len;
        logic [7:0] ftype;
        stop_at = words_queued + target;
        while (words_queued < stop_at) begin
            pick = $urandom_range(99);
            if (pick < 82) begin
                case ($urandom_range(9))
                    0, 1, 2, 3, 4: ftype = cfg_now.expected_type;
                    5, 6:          ftype = cfg_now.data_code;
                    7, 8:          ftype = cfg_now.ack_code;
                    default:       ftype = 8'($urandom);
                endcase
                len = ($urandom_range(99) < 88) ? $urandom_range(8) : $urandom_range(40, 9);
                queue_frame(ftype, len, $urandom_range(99) < 35, $urandom_range(99) < 80,
                            pick >= 70);
            end else if (pick < 92) begin
                push_noise($urandom_range(4, 1));
            end else begin
                push_word(efr_pkg::CMD_TIMEOUT, 8'($urandom));
            end
        end
    endtask

    task automatic write_reg(input logic [2:0] idx, input logic [7:0] value);
        @(posedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= value;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        case (idx)
            efr_pkg::CFG_EXPECTED_TYPE: cfg_now.expected_type = value;
            efr_pkg::CFG_START_CODE:    cfg_now.start_code    = value;
            efr_pkg::CFG_ESCAPE_CODE:   cfg_now.escape_code   = value;
            efr_pkg::CFG_DATA_CODE:     cfg_now.data_code     = value;
            efr_pkg::CFG_ACK_CODE:      cfg_now.ack_code      = value;
            efr_pkg::CFG_BREAK_CODE:    cfg_now.break_code    = value;
            default: ;
        endcase
    endtask

    task automatic write_all(input logic [7:0] exp_type, input logic [7:0] start,
                             input logic [7:0] esc, input logic [7:0] data,
                             input logic [7:0] ack, input logic [7:0] brk);
        write_reg(efr_pkg::CFG_EXPECTED_TYPE, exp_type);
        write_reg(efr_pkg::CFG_START_CODE, start);
        write_reg(efr_pkg::CFG_ESCAPE_CODE, esc);
        write_reg(efr_pkg::CFG_DATA_CODE, data);
        write_reg(efr_pkg::CFG_ACK_CODE, ack);
        write_reg(efr_pkg::CFG_BREAK_CODE, brk);
        settings_count++;
    endtask

    // The sender holds back until the stream is out and every result has come, then the
    // block is given time to finish any word that causes no result.
    task automatic settle();
        while (rx_stream.size() != 0 || in_ch.valid || pending_results.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    initial begin
        i_rst_n       = 1'b0;
        i_cfg_we      = 1'b0;
        i_cfg_idx     = efr_pkg::CFG_EXPECTED_TYPE;
        i_cfg_data    = 8'h00;
        in_ch.valid   = 1'b0;
        in_ch.cmd     = efr_pkg::CMD_BYTE;
        in_ch.rx_byte = 8'h00;
        out_ch.ready  = 1'b0;
        cfg_now = '{expected_type: efr_pkg::RST_EXPECTED_TYPE,
                    start_code: efr_pkg::RST_START_CODE,
                    escape_code: efr_pkg::RST_ESCAPE_CODE,
                    data_code: efr_pkg::RST_DATA_CODE,
                    ack_code: efr_pkg::RST_ACK_CODE,
                    break_code: efr_pkg::RST_BREAK_CODE};
        rx_phase  = RX_HUNT;
        esc_armed = 1'b0;
        len_seen  = 8'h00;
        type_seen = 8'h00;
        pay_pos   = 8'h00;
        csum_acc  = 8'h00;
        ack_held  = 8'h00;
        break_on  = 1'b0;
        settings_count = 1;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Reset settings. A timeout while hunting, then a raw ff and a raw escape code that hunting ignores.
        push_word(efr_pkg::CMD_TIMEOUT, 8'h00);
        rx_stream.push_back('{cmd: efr_pkg::CMD_BYTE, rx_byte: 8'hff});
        rx_stream.push_back('{cmd: efr_pkg::CMD_BYTE, rx_byte: cfg_now.escape_code});
        // Data frame carrying 00, ff and an escaped escape code.
        push_word(efr_pkg::CMD_BYTE, cfg_now.start_code);
        push_word(efr_pkg::CMD_BYTE, 8'd3);
        push_word(efr_pkg::CMD_BYTE, cfg_now.data_code);
        push_word(efr_pkg::CMD_BYTE, 8'h00);
        push_word(efr_pkg::CMD_BYTE, 8'hff);
        push_word(efr_pkg::CMD_BYTE, cfg_now.escape_code);
        push_word(efr_pkg::CMD_BYTE, cfg_now.escape_code ^ efr_pkg::XOR_MASK);
        push_word(efr_pkg::CMD_BYTE,
                  8'(efr_pkg::SUM_GOOD - (cfg_now.data_code + 8'hff + cfg_now.escape_code)));
        // Escape then escape, and a start code taken as data; the checksum is wrong.
        push_word(efr_pkg::CMD_BYTE, cfg_now.start_code);
        push_word(efr_pkg::CMD_BYTE, 8'd2);
        push_word(efr_pkg::CMD_BYTE, cfg_now.data_code);
        push_word(efr_pkg::CMD_BYTE, cfg_now.escape_code);
        push_word(efr_pkg::CMD_BYTE, cfg_now.escape_code);
        push_word(efr_pkg::CMD_BYTE, cfg_now.start_code);
        push_word(efr_pkg::CMD_BYTE, 8'h00);
        // Zero length data frame with a good checksum.
        push_word(efr_pkg::CMD_BYTE, cfg_now.start_code);
        push_word(efr_pkg::CMD_BYTE, 8'h00);
        push_word(efr_pkg::CMD_BYTE, cfg_now.data_code);
        push_word(efr_pkg::CMD_BYTE, efr_pkg::SUM_GOOD - cfg_now.data_code);
        // Ack frame of a type not accepted: no result, but the ack value is taken.
        push_word(efr_pkg::CMD_BYTE, cfg_now.start_code);
        push_word(efr_pkg::CMD_BYTE, 8'd1);
        push_word(efr_pkg::CMD_BYTE, cfg_now.ack_code);
        push_word(efr_pkg::CMD_BYTE, cfg_now.break_code);
        push_word(efr_pkg::CMD_BYTE,
                  8'(efr_pkg::SUM_GOOD - (cfg_now.ack_code + cfg_now.break_code)));
        // Frame aborted by a timeout with an escape still pending.
        push_word(efr_pkg::CMD_BYTE, cfg_now.start_code);
        push_word(efr_pkg::CMD_BYTE, 8'd5);
        push_word(efr_pkg::CMD_BYTE, cfg_now.escape_code);
        push_word(efr_pkg::CMD_TIMEOUT, 8'hff);
        queue_frame(cfg_now.data_code, 255, 1'b0, 1'b1, 1'b0);
        random_traffic(120);
        settle();

        // Acks accepted: break requests, including a zero length ack.
        write_reg(efr_pkg::CFG_EXPECTED_TYPE, cfg_now.ack_code);
        settings_count++;
        queue_frame(cfg_now.ack_code, 1, 1'b1, 1'b1, 1'b0);
        queue_frame(cfg_now.ack_code, 0, 1'b0, 1'b1, 1'b0);
        queue_frame(cfg_now.ack_code, 2, 1'b0, 1'b0, 1'b0);
        queue_frame(cfg_now.data_code, 3, 1'b0, 1'b1, 1'b0);
        random_traffic(100);
        settle();

        write_all(8'h00, 8'h00, 8'hff, 8'h00, 8'hff, 8'hff);
        random_traffic(90);
        settle();

        write_all(8'hff, 8'hff, 8'h00, 8'h00, 8'hff, 8'h00);
        write_reg(CFG_SPARE_LO, 8'($urandom));
        write_reg(CFG_SPARE_HI, 8'($urandom));
        queue_frame(cfg_now.ack_code, 1, 1'b1, 1'b1, 1'b0);
        random_traffic(90);
        settle();

        write_all(8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom),
                  8'($urandom));
        write_reg(efr_pkg::CFG_EXPECTED_TYPE,
                  ($urandom_range(1) != 0) ? cfg_now.data_code : cfg_now.ack_code);
        random_traffic(80);
        settle();

        // One code for data, ack and accepted type alike.
        write_all(8'h5a, efr_pkg::RST_START_CODE, efr_pkg::RST_ESCAPE_CODE, 8'h5a, 8'h5a,
                  8'($urandom));
        random_traffic(50);
        settle();

        if (pending_results.size() != 0) begin
            note_mismatch($sformatf("%0d results never arrived", pending_results.size()));
        end
        $display("Summary: %0d input words under %0d register settings, %0d results checked.",
                 words_sent, settings_count, results_seen);
        $display("Summary: %0d payload bytes, %0d frame status words, %0d of them breaks.",
                 payload_count, status_count, break_count);
        if (fail_count == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule

// ===== filelist.f =====
hw/rtl/efr_pkg.sv
hw/rtl/efr_in_if.sv
hw/rtl/efr_out_if.sv
hw/rtl/efr_front.sv
hw/rtl/efr_queue.sv
hw/rtl/efr_back.sv
hw/rtl/escaped_frame_receiver_unit.sv
tb/sv/tb_escaped_frame_receiver_unit.sv
